[sv/pfr_pkg.sv]
package pfr_pkg;

    localparam int HALF_PHASES = 16;
    localparam int MAX_TAPS    = 21;
    localparam int CHANNELS    = 2;
    localparam int MAX_RESULTS = 8;
    localparam int PHASE_ROWS  = 2 * HALF_PHASES + 1;

    // Port field widths.
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int RATIO_W    = 20;
    localparam int ORDER_W    = 5;
    localparam int CH_W       = 1;
    localparam int PHASE_IN_W = 6;
    localparam int TAP_IN_W   = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_W      = 20;

    // Output time, signed Q8.16.
    localparam int TIME_W = 24;
    localparam int FRAC_W = 16;
    localparam int TINT_W = TIME_W - FRAC_W;

    localparam int PH_W   = $clog2(PHASE_ROWS + HALF_PHASES);
    localparam int PHT_W  = FRAC_W + PH_W + 1;
    localparam int TAP_W  = $clog2(MAX_TAPS);
    localparam int FILL_W = $clog2(MAX_TAPS + 1);
    localparam int AGE_W  = TINT_W + TAP_W;
    localparam int N_W    = $clog2(MAX_RESULTS + 1);

    localparam int HRAM_DEPTH = CHANNELS * MAX_TAPS;
    localparam int HRAM_AW    = $clog2(HRAM_DEPTH);
    localparam int CRAM_DEPTH = PHASE_ROWS * MAX_TAPS;
    localparam int CRAM_AW    = $clog2(CRAM_DEPTH);

    localparam int PROD_W = SAMPLE_W + COEF_W;
    localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS) + 1;

    localparam int ONE_Q16  = 1 << FRAC_W;
    localparam int TIME_MIN = -64 * ONE_Q16;
    localparam int Q_MAX    = (1 << (SAMPLE_W - 1)) - 1;
    localparam int Q_MIN    = -(1 << (SAMPLE_W - 1));

    localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(65536);
    localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(19);

    localparam logic [CFG_IDX_W-1:0] REG_RATIO = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER = 1'b1;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_COEF   = 1'b1;

    typedef struct packed {
        logic load;
        logic coef_wr;
        logic start;
        logic issue;
        logic advance;
        logic push;
        logic writeback;
    } pfr_cmd_t;

    typedef struct packed {
        logic due;
        logic tap_last;
        logic pipe_busy;
        logic out_free;
    } pfr_stat_t;

endpackage

[sv/polyphase_fir_resampler.sv]
// Channel   Handshake              Contents
// input     in_valid / in_ready    mode, channel, sample, coef_phase, coef_tap, coef_value
// output    out_valid / out_ready  out_channel, out_sample, clipped, last
// config    cfg_we                 cfg_index, cfg_data (no wait, no read-back)
//
// A coefficient write is taken in the idle state without leaving it. An audio sample gives
// n results (at most eight), with L the effective filter order; the single multiplier,
// fed from the history and coefficient memories one tap a cycle, takes L + 1 taps for each.
// Reset clears the time accumulators and the history fill counts; no clearing pass is run.
// A result waits in the output register; the next sample is taken while it waits, and the
// sequencer holds before loading a further result until the previous one has transferred.
module polyphase_fir_resampler (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pfr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pfr_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                mode,
    input  logic [pfr_pkg::CH_W-1:0]            channel,
    input  logic signed [pfr_pkg::SAMPLE_W-1:0] sample,
    input  logic [pfr_pkg::PHASE_IN_W-1:0]      coef_phase,
    input  logic [pfr_pkg::TAP_IN_W-1:0]        coef_tap,
    input  logic signed [pfr_pkg::COEF_W-1:0]   coef_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [pfr_pkg::CH_W-1:0]            out_channel,
    output logic signed [pfr_pkg::SAMPLE_W-1:0] out_sample,
    output logic                                clipped,
    output logic                                last
);

    import pfr_pkg::*;

    pfr_cmd_t  cmd;
    pfr_stat_t stat;

    pfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mode     (mode),
        .channel  (channel),
        .stat     (stat),
        .cmd      (cmd)
    );

    pfr_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .channel     (channel),
        .sample      (sample),
        .coef_phase  (coef_phase),
        .coef_tap    (coef_tap),
        .coef_value  (coef_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_channel (out_channel),
        .out_sample  (out_sample),
        .clipped     (clipped),
        .last        (last)
    );

endmodule

[sv/pfr_ram.sv]
module pfr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/pfr_ctrl.sv]
module pfr_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        mode,
    input  logic [pfr_pkg::CH_W-1:0]    channel,
    input  pfr_pkg::pfr_stat_t          stat,
    output pfr_pkg::pfr_cmd_t           cmd
);

    import pfr_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_MAC   = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_ADV   = 3'd5;
    localparam logic [2:0] S_PUSH  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (mode == MODE_COEF)
                    begin
                        cmd.coef_wr = 1'b1;
                    end
                    else if (int'(channel) < CHANNELS)
                    begin
                        cmd.load   = 1'b1;
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (stat.due)
                begin
                    state_next = S_START;
                end
                else
                begin
                    cmd.writeback = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_START:
            begin
                cmd.start  = 1'b1;
                state_next = S_MAC;
            end
            S_MAC:
            begin
                cmd.issue = 1'b1;
                if (stat.tap_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = S_ADV;
                end
            end
            S_ADV:
            begin
                cmd.advance = 1'b1;
                state_next  = S_PUSH;
            end
            S_PUSH:
            begin
                if (stat.out_free)
                begin
                    cmd.push = 1'b1;
                    if (stat.due)
                    begin
                        state_next = S_START;
                    end
                    else
                    begin
                        cmd.writeback = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[sv/pfr_datapath.sv]
module pfr_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pfr_pkg::pfr_cmd_t                   cmd,
    output pfr_pkg::pfr_stat_t                  stat,
    input  logic                                cfg_we,
    input  logic [pfr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pfr_pkg::CFG_W-1:0]           cfg_data,
    input  logic [pfr_pkg::CH_W-1:0]            channel,
    input  logic signed [pfr_pkg::SAMPLE_W-1:0] sample,
    input  logic [pfr_pkg::PHASE_IN_W-1:0]      coef_phase,
    input  logic [pfr_pkg::TAP_IN_W-1:0]        coef_tap,
    input  logic signed [pfr_pkg::COEF_W-1:0]   coef_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [pfr_pkg::CH_W-1:0]            out_channel,
    output logic signed [pfr_pkg::SAMPLE_W-1:0] out_sample,
    output logic                                clipped,
    output logic                                last
);

    import pfr_pkg::*;

    // Configuration.
    logic [RATIO_W-1:0] ratio_reg;
    logic [ORDER_W-1:0] order_reg;

    // Per-channel state.
    logic signed [TIME_W-1:0] time_acc_reg [CHANNELS];
    logic [TAP_W-1:0]         wp_reg       [CHANNELS];
    logic [FILL_W-1:0]        fill_reg     [CHANNELS];

    // Working registers for the item in hand.
    logic [CH_W-1:0]          ch_reg;
    logic signed [TIME_W-1:0] z_reg;
    logic [N_W-1:0]           n_reg;
    logic [FILL_W-1:0]        tap_reg;
    logic [CRAM_AW-1:0]       row_base_reg;
    logic signed [AGE_W-1:0]  base_age_reg;

    // MAC pipeline.
    logic                      rd_v_reg;
    logic                      ok_reg;
    logic                      prod_v_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;

    // Output register.
    logic                       out_valid_reg;
    logic [CH_W-1:0]            out_channel_reg;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic                       clipped_reg;
    logic                       last_reg;

    logic [ORDER_W-1:0]         order_eff;
    logic [ORDER_W-1:0]         half;
    logic [ORDER_W-1:0]         r_val;
    logic signed [AGE_W-1:0]    fz_ext;
    logic signed [AGE_W-1:0]    due_sum;
    logic [FRAC_W-1:0]          frac;
    logic [PHT_W-1:0]           ph_prod;
    logic [PH_W-1:0]            phase0;
    logic [PH_W-1:0]            phase1;
    logic [PH_W-1:0]            phase_sat;
    logic signed [AGE_W-1:0]    age;
    logic                       age_ok;
    logic [TAP_W-1:0]           age_idx;
    logic [TAP_W:0]             pos_diff;
    logic [TAP_W:0]             pos_wrap;
    logic [TAP_W-1:0]           pos;
    logic [TAP_W-1:0]           wp_new;
    logic signed [TIME_W:0]     z_sub;
    logic signed [ACC_W-1:0]    acc_rnd;
    logic signed [ACC_W-1:0]    q_full;
    logic signed [SAMPLE_W-1:0] q_sat;
    logic                       q_clip;
    logic                       coef_we;
    logic [HRAM_AW-1:0]         h_waddr;
    logic [HRAM_AW-1:0]         h_raddr;
    logic [CRAM_AW-1:0]         c_waddr;
    logic [CRAM_AW-1:0]         c_raddr;
    logic [SAMPLE_W-1:0]        h_rdata;
    logic [COEF_W-1:0]          c_rdata;
    logic signed [SAMPLE_W-1:0] h_tap;

    always_comb
    begin
        order_eff = (int'(order_reg) > MAX_TAPS - 1) ? ORDER_W'(MAX_TAPS - 1) : order_reg;
        half      = order_eff >> 1;
        r_val     = order_eff - half;

        // An output is due while floor(z) + R + 1 is not above zero and fewer than eight have been made.
        fz_ext  = AGE_W'($signed(z_reg[TIME_W-1:FRAC_W]));
        due_sum = fz_ext + $signed(AGE_W'(r_val)) + $signed(AGE_W'(1));

        frac      = z_reg[FRAC_W-1:0];
        ph_prod   = PHT_W'(frac) * PHT_W'(2 * HALF_PHASES) + PHT_W'(1 << (FRAC_W - 1));
        phase0    = ph_prod[FRAC_W +: PH_W];
        phase1    = order_eff[0] ? phase0 : phase0 + PH_W'(HALF_PHASES);
        phase_sat = (int'(phase1) > 2 * HALF_PHASES) ? PH_W'(2 * HALF_PHASES) : phase1;

        // Age of the tap now issued, and where that sample sits in the ring.
        age      = base_age_reg - $signed(AGE_W'(tap_reg));
        age_ok   = (age >= 0) && (age < $signed(AGE_W'(fill_reg[ch_reg])));
        age_idx  = age[TAP_W-1:0];
        pos_diff = {1'b0, wp_reg[ch_reg]} - {1'b0, age_idx};
        pos_wrap = pos_diff + (TAP_W + 1)'(MAX_TAPS);
        pos      = pos_diff[TAP_W] ? pos_wrap[TAP_W-1:0] : pos_diff[TAP_W-1:0];

        wp_new = (int'(wp_reg[channel]) == MAX_TAPS - 1) ? '0 : wp_reg[channel] + 1'b1;

        z_sub = $signed({time_acc_reg[channel][TIME_W-1], time_acc_reg[channel]})
                - $signed((TIME_W + 1)'(ONE_Q16));

        // Round half up from Q.15, then saturate.
        acc_rnd = acc_reg + $signed(ACC_W'(1 << (COEF_W - 2)));
        q_full  = acc_rnd >>> (COEF_W - 1);
        if (q_full > $signed(ACC_W'(Q_MAX)))
        begin
            q_sat  = SAMPLE_W'(Q_MAX);
            q_clip = 1'b1;
        end
        else if (q_full < $signed(ACC_W'(Q_MIN)))
        begin
            q_sat  = SAMPLE_W'(Q_MIN);
            q_clip = 1'b1;
        end
        else
        begin
            q_sat  = q_full[SAMPLE_W-1:0];
            q_clip = 1'b0;
        end

        coef_we = cmd.coef_wr && (int'(coef_phase) < PHASE_ROWS)
                  && (int'(coef_tap) < MAX_TAPS);
        c_waddr = CRAM_AW'(int'(coef_phase) * MAX_TAPS + int'(coef_tap));
        c_raddr = row_base_reg + CRAM_AW'(tap_reg);
        h_waddr = HRAM_AW'(int'(channel) * MAX_TAPS + int'(wp_new));
        h_raddr = HRAM_AW'(int'(ch_reg) * MAX_TAPS + int'(pos));
        h_tap   = ok_reg ? $signed(h_rdata) : '0;

        stat.due       = (int'(n_reg) < MAX_RESULTS) && (due_sum <= 0);
        stat.tap_last  = (tap_reg == FILL_W'(order_eff));
        stat.pipe_busy = rd_v_reg || prod_v_reg;
        stat.out_free  = !out_valid_reg || out_ready;
    end

    pfr_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (HRAM_DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (cmd.load),
        .waddr (h_waddr),
        .wdata (sample),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    pfr_ram #(
        .WIDTH (COEF_W),
        .DEPTH (CRAM_DEPTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (c_waddr),
        .wdata (coef_value),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg     <= RATIO_RESET;
            order_reg     <= ORDER_RESET;
            rd_v_reg      <= 1'b0;
            prod_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                time_acc_reg[c] <= '0;
                wp_reg[c]       <= '0;
                fill_reg[c]     <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RATIO: ratio_reg <= cfg_data[RATIO_W-1:0];
                    REG_ORDER: order_reg <= cfg_data[ORDER_W-1:0];
                    default:   ratio_reg <= ratio_reg;
                endcase
            end

            if (cmd.load)
            begin
                wp_reg[channel] <= wp_new;
                if (int'(fill_reg[channel]) < MAX_TAPS)
                begin
                    fill_reg[channel] <= fill_reg[channel] + 1'b1;
                end
            end

            if (cmd.writeback)
            begin
                time_acc_reg[ch_reg] <= z_reg;
            end

            rd_v_reg   <= cmd.issue;
            prod_v_reg <= rd_v_reg;

            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ch_reg <= channel;
            n_reg  <= '0;
            if (z_sub < $signed((TIME_W + 1)'(TIME_MIN)))
            begin
                z_reg <= TIME_W'(TIME_MIN);
            end
            else
            begin
                z_reg <= z_sub[TIME_W-1:0];
            end
        end
        else if (cmd.advance)
        begin
            z_reg <= z_reg + $signed(TIME_W'(ratio_reg));
            n_reg <= n_reg + 1'b1;
        end

        if (cmd.start)
        begin
            row_base_reg <= CRAM_AW'(int'(phase_sat) * MAX_TAPS);
            // -(floor(z) + 1) is the complement of floor(z).
            base_age_reg <= ~fz_ext + $signed(AGE_W'(half));
            tap_reg      <= '0;
        end
        else if (cmd.issue)
        begin
            tap_reg <= tap_reg + 1'b1;
        end

        if (cmd.issue)
        begin
            ok_reg <= age_ok;
        end

        prod_reg <= h_tap * $signed(c_rdata);

        if (cmd.start)
        begin
            acc_reg <= '0;
        end
        else if (prod_v_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end

        if (cmd.push)
        begin
            out_channel_reg <= ch_reg;
            out_sample_reg  <= q_sat;
            clipped_reg     <= q_clip;
            last_reg        <= !stat.due;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_channel = out_channel_reg;
    assign out_sample  = out_sample_reg;
    assign clipped     = clipped_reg;
    assign last        = last_reg;

endmodule

[sim/tb_polyphase_fir_resampler.sv]
module tb_polyphase_fir_resampler;
    import pfr_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 250;
    localparam int LONG_HOLD     = 400;
    localparam int N_PHASES      = 5;

    typedef struct packed {
        logic [CH_W-1:0]     ch;
        logic [SAMPLE_W-1:0] value;
        logic                clip;
        logic                last;
    } out_rec_t;

    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_W-1:0]      reg_val;
        logic                  md;
        logic [CH_W-1:0]       ch;
        logic [SAMPLE_W-1:0]   smp;
        logic [PHASE_IN_W-1:0] row;
        logic [TAP_IN_W-1:0]   tap;
        logic [COEF_W-1:0]     cval;
        logic                  typed;
        logic [SAMPLE_W-1:0]   exp_val;
        logic                  exp_clip;
    } stim_row_t;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_we;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_W-1:0]            cfg_data;
    logic                        in_valid;
    logic                        in_ready;
    logic                        mode;
    logic [CH_W-1:0]             channel;
    logic signed [SAMPLE_W-1:0]  sample;
    logic [PHASE_IN_W-1:0]       coef_phase;
    logic [TAP_IN_W-1:0]         coef_tap;
    logic signed [COEF_W-1:0]    coef_value;
    logic                        out_valid;
    logic                        out_ready;
    logic [CH_W-1:0]             out_channel;
    logic signed [SAMPLE_W-1:0]  out_sample;
    logic                        clipped;
    logic                        last;

    // Predictor state, mirroring the block.
    logic signed [SAMPLE_W-1:0] hist_line [CHANNELS][MAX_TAPS];
    longint                     out_time [CHANNELS];
    logic signed [COEF_W-1:0]   coef_mem [PHASE_ROWS][MAX_TAPS];
    logic [RATIO_W-1:0]         step_ratio;
    logic [ORDER_W-1:0]         order_reg;
    out_rec_t                   due_outputs [$];

    int errors;
    int items_in;
    int outputs_out;
    int reg_writes;
    int settings_run;
    int long_holds;
    int cycle_count;
    bit idling_on;
    bit long_hold_req;

    polyphase_fir_resampler i_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        stim_row_t r;
        r = '0;
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = CFG_W'(val);
        return r;
    endfunction

    function automatic stim_row_t coef_row(int row, int tap, int value);
        stim_row_t r;
        r = '0;
        r.md   = MODE_COEF;
        r.row  = PHASE_IN_W'(row);
        r.tap  = TAP_IN_W'(tap);
        r.cval = COEF_W'(value);
        return r;
    endfunction

    function automatic stim_row_t sample_row(int ch, int value);
        stim_row_t r;
        r = '0;
        r.md  = MODE_SAMPLE;
        r.ch  = CH_W'(ch);
        r.smp = SAMPLE_W'(value);
        return r;
    endfunction

    function automatic stim_row_t checked_row(int ch, int value, int want, bit clip);
        stim_row_t r;
        r = sample_row(ch, value);
        r.typed    = 1'b1;
        r.exp_val  = SAMPLE_W'(want);
        r.exp_clip = clip;
        return r;
    endfunction

    function automatic int small_coef();
        return int'($urandom_range(0, 8191)) - 4096;
    endfunction

    function automatic stim_row_t random_item(int ch0_weight);
        int k;
        int ch;
        k  = $urandom_range(0, 9);
        ch = (int'($urandom_range(0, 15)) < ch0_weight) ? 0 : 1;
        if (k == 0)
            return coef_row($urandom_range(0, 63), $urandom_range(0, 31),
                            $urandom_range(0, 65535));
        if (k == 1)
            return coef_row($urandom_range(0, PHASE_ROWS - 1), $urandom_range(0, MAX_TAPS - 1),
                            small_coef());
        if ($urandom_range(0, 3) == 0)
            return sample_row(ch, $urandom_range(0, 1) ? 32767 : -32768);
        return sample_row(ch, $urandom_range(0, 65535));
    endfunction

    // Works out the resampled outputs that one accepted transfer causes and queues them.
    function automatic int predict_outputs(stim_row_t it);
        longint   z;
        longint   fz;
        longint   frac;
        longint   phase;
        longint   acc;
        longint   q;
        longint   age;
        int       taps_l;
        int       half;
        int       lead;
        int       n;
        int       a;
        int       i;
        out_rec_t rec;
        n = 0;
        if (it.md == MODE_COEF) begin
            if (it.row < PHASE_ROWS && it.tap < MAX_TAPS)
                coef_mem[it.row][it.tap] = it.cval;
            return 0;
        end
        for (a = MAX_TAPS - 1; a > 0; a--)
            hist_line[it.ch][a] = hist_line[it.ch][a-1];
        hist_line[it.ch][0] = it.smp;

        z = out_time[it.ch] - ONE_Q16;
        if (z < TIME_MIN)
            z = TIME_MIN;
        taps_l = (order_reg > MAX_TAPS - 1) ? MAX_TAPS - 1 : int'(order_reg);
        half   = taps_l / 2;
        lead   = taps_l - half;

        while (n < MAX_RESULTS) begin
            fz = z >>> FRAC_W;
            if (fz > -lead - 1)
                break;
            frac  = z - (fz <<< FRAC_W);
            phase = (frac * (2 * HALF_PHASES) + ONE_Q16 / 2) >>> FRAC_W;
            // An even order sits half a sample later in the table.
            if (taps_l % 2 == 0)
                phase += HALF_PHASES;
            if (phase > 2 * HALF_PHASES)
                phase = 2 * HALF_PHASES;
            acc = 0;
            for (i = 0; i <= taps_l; i++) begin
                age = -(fz + 1) + half - i;
                if (age >= 0 && age < MAX_TAPS)
                    acc += longint'(hist_line[it.ch][age]) * longint'(coef_mem[phase][i]);
            end
            q = (acc + 16384) >>> 15;
            rec.clip = 1'b0;
            if (q > Q_MAX) begin
                q = Q_MAX;
                rec.clip = 1'b1;
            end else if (q < Q_MIN) begin
                q = Q_MIN;
                rec.clip = 1'b1;
            end
            rec.ch    = it.ch;
            rec.value = SAMPLE_W'(q);
            rec.last  = 1'b0;
            due_outputs.push_back(rec);
            n++;
            z += longint'(step_ratio);
        end
        if (n > 0) begin
            rec = due_outputs.pop_back();
            rec.last = 1'b1;
            due_outputs.push_back(rec);
        end
        out_time[it.ch] = z;
        return n;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_RATIO)
            step_ratio = val[RATIO_W-1:0];
        else
            order_reg = val[ORDER_W-1:0];
        reg_writes++;
    endtask

    // Holds the input until every expected result has arrived and the block has gone quiet.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (due_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_item(stim_row_t it);
        int       gap;
        int       n;
        out_rec_t typed_rec;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        mode       <= it.md;
        channel    <= it.ch;
        sample     <= it.smp;
        coef_phase <= it.row;
        coef_tap   <= it.tap;
        coef_value <= it.cval;
        do @(posedge clk); while (!in_ready);
        items_in++;
        n = predict_outputs(it);
        // Rows with a result written out by hand replace what the predictor queued.
        if (it.typed) begin
            repeat (n) void'(due_outputs.pop_back());
            typed_rec.ch    = it.ch;
            typed_rec.value = it.exp_val;
            typed_rec.clip  = it.exp_clip;
            typed_rec.last  = 1'b1;
            due_outputs.push_back(typed_rec);
        end
    endtask

    // Output side: random stalls, plus one long hold-off so the block backs up.
    initial
    begin
        int quiet;
        quiet     = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (quiet == 0) begin
                if (long_hold_req && out_valid) begin
                    quiet         = LONG_HOLD;
                    long_hold_req = 1'b0;
                    long_holds++;
                end else if (idling_on && $urandom_range(0, 7) == 0) begin
                    quiet = $urandom_range(1, 19);
                end
            end
            if (quiet > 0) begin
                out_ready <= 1'b0;
                quiet--;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        out_rec_t want;
        if (rst_n && out_valid && out_ready) begin
            outputs_out++;
            if (due_outputs.size() == 0) begin
                $error("unexpected result transfer: out_channel %0d out_sample %0d",
                       out_channel, out_sample);
                errors++;
            end else begin
                want = due_outputs.pop_front();
                if (out_channel !== want.ch) begin
                    $error("out_channel: expected %0d, actual %0d", want.ch, out_channel);
                    errors++;
                end
                if (out_sample !== want.value) begin
                    $error("out_sample: expected %0d, actual %0d",
                           $signed(want.value), out_sample);
                    errors++;
                end
                if (clipped !== want.clip) begin
                    $error("clipped: expected %0d, actual %0d", want.clip, clipped);
                    errors++;
                end
                if (last !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, last);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin
        stim_row_t   dir_rows [$];
        int unsigned ph_ratio [N_PHASES];
        int unsigned ph_order [N_PHASES];
        int          ph_items [N_PHASES];
        int          ph_ch0 [N_PHASES];
        bit          ph_idle [N_PHASES];
        int          n;

        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        mode       = MODE_SAMPLE;
        channel    = '0;
        sample     = '0;
        coef_phase = '0;
        coef_tap   = '0;
        coef_value = '0;

        errors        = 0;
        items_in      = 0;
        outputs_out   = 0;
        reg_writes    = 0;
        settings_run  = 0;
        long_holds    = 0;
        idling_on     = 1'b1;
        long_hold_req = 1'b0;

        for (int c = 0; c < CHANNELS; c++) begin
            out_time[c] = 0;
            for (int a = 0; a < MAX_TAPS; a++)
                hist_line[c][a] = '0;
        end
        step_ratio = RATIO_RESET;
        order_reg  = ORDER_RESET;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Every coefficient is written before any output can read the table.
        for (int r = 0; r < PHASE_ROWS; r++)
            for (int t = 0; t < MAX_TAPS; t++)
                send_item(coef_row(r, t, small_coef()));

        // With order 2 and a step of one sample, row 16 holds the taps and the middle one
        // is exactly minus one, so each output is the previous sample negated.
        dir_rows.push_back(cfg_row(REG_ORDER, 20'hFFFE2));
        dir_rows.push_back(cfg_row(REG_RATIO, 65536));
        dir_rows.push_back(coef_row(16, 0, 0));
        dir_rows.push_back(coef_row(16, 1, -32768));
        dir_rows.push_back(coef_row(16, 2, 0));
        dir_rows.push_back(coef_row(63, 5, 16'h1234));
        dir_rows.push_back(coef_row(0, 31, 32767));
        dir_rows.push_back(coef_row(32, 20, 32767));
        dir_rows.push_back(sample_row(0, 32767));
        dir_rows.push_back(checked_row(0, -32768, -32767, 1'b0));
        dir_rows.push_back(checked_row(0, 0, 32767, 1'b1));
        dir_rows.push_back(sample_row(1, 100));
        dir_rows.push_back(checked_row(1, -1, -100, 1'b0));
        dir_rows.push_back(checked_row(0, 5, 0, 1'b0));
        dir_rows.push_back(checked_row(0, -32768, -5, 1'b0));
        // An eighth of a sample per output: eight results, the late phases saturating the row.
        dir_rows.push_back(cfg_row(REG_RATIO, 8192));
        dir_rows.push_back(sample_row(0, 32767));
        dir_rows.push_back(sample_row(0, -32768));
        dir_rows.push_back(cfg_row(REG_ORDER, 1));
        dir_rows.push_back(sample_row(1, -32768));
        // Order zero makes sixteen outputs due at once; only eight may leave.
        dir_rows.push_back(cfg_row(REG_ORDER, 0));
        dir_rows.push_back(sample_row(1, 12345));
        dir_rows.push_back(cfg_row(REG_ORDER, 20'hFFFFF));
        dir_rows.push_back(cfg_row(REG_RATIO, 20'hFFFFF));
        dir_rows.push_back(sample_row(0, 1));

        foreach (dir_rows[k]) begin
            if (dir_rows[k].is_cfg) begin
                settle();
                write_reg(dir_rows[k].reg_idx, dir_rows[k].reg_val);
            end else begin
                send_item(dir_rows[k]);
            end
        end
        settings_run++;

        // A zero step runs time far into the past, past the history and into the floor.
        ph_ratio = '{65536, 0, 20'hFFFFF, $urandom_range(8192, 1048575),
                     $urandom_range(0, 1048575)};
        ph_order = '{19, 2, 20, $urandom_range(2, 20), $urandom_range(0, 31)};
        ph_items = '{16, 72, 16, 16, 16};
        ph_ch0   = '{8, 15, 8, 8, 8};
        ph_idle  = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0};

        for (int p = 0; p < N_PHASES; p++) begin
            settle();
            write_reg(REG_RATIO, CFG_W'(ph_ratio[p]));
            write_reg(REG_ORDER, CFG_W'(($urandom() & 32'hFFFE0) | ph_order[p]));
            settings_run++;
            idling_on = ph_idle[p];
            if (p == 1)
                long_hold_req = 1'b1;
            n = 0;
            while (n < ph_items[p]) begin
                send_item(random_item(ph_ch0[p]));
                n++;
            end
        end

        settle();
        $display("Covered %0d input transfers and %0d result transfers over %0d settings",
                 items_in, outputs_out, settings_run);
        $display("(%0d register writes, %0d long output stalls), with %0d mismatches.",
                 reg_writes, long_holds, errors);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
